// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/rlt_pkg.sv =====
// ----------------------------------------------------------------------------
// rlt_pkg
// Shared widths, operation codes and structs of the redundant load table.
// ----------------------------------------------------------------------------
package rlt_pkg;

    // Field widths of the statement and result words
    localparam int OP_W   = 2;
    localparam int REF_W  = 16;
    localparam int SIZE_W = 2;

    // Table geometry
    localparam int TABLE_ENTRIES = 16;
    localparam int REF_BITS      = 16;
    // Bits of a ref that take part in storage and compare
    localparam int KEY_W = (REF_BITS < REF_W) ? REF_BITS : REF_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd1;
    localparam logic [OP_W-1:0] OP_OTHER = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [REF_W-1:0]  address_ref;
        logic [SIZE_W-1:0] access_size;
        logic [REF_W-1:0]  result_ref;
    } t_item;

    typedef struct packed {
        logic             rewrite_as_copy;
        logic [REF_W-1:0] copy_source_ref;
        logic             insert_dropped;
    } t_result;

    // Statement presented to the table, with commit strobe
    typedef struct packed {
        logic  commit;
        t_item item;
    } t_req;

endpackage

// ===== rtl/rlt_if.sv =====
// ----------------------------------------------------------------------------
// rlt_if
// Valid/ready channels carrying statement words and result words.
// ----------------------------------------------------------------------------
interface rlt_in_if;
    logic                          valid;
    logic                          ready;
    logic [rlt_pkg::OP_W-1:0]      operation;
    logic [rlt_pkg::REF_W-1:0]     address_ref;
    logic [rlt_pkg::SIZE_W-1:0]    access_size;
    logic [rlt_pkg::REF_W-1:0]     result_ref;

    modport source (output valid, operation, address_ref, access_size, result_ref,
                    input ready);
    modport sink   (input valid, operation, address_ref, access_size, result_ref,
                    output ready);
endinterface

interface rlt_out_if;
    logic                          valid;
    logic                          ready;
    logic                          rewrite_as_copy;
    logic [rlt_pkg::REF_W-1:0]     copy_source_ref;
    logic                          insert_dropped;

    modport source (output valid, rewrite_as_copy, copy_source_ref, insert_dropped,
                    input ready);
    modport sink   (input valid, rewrite_as_copy, copy_source_ref, insert_dropped,
                    output ready);
endinterface

// ===== rtl/rlt_in_reg.sv =====
// ----------------------------------------------------------------------------
// rlt_in_reg
// Input register: captures one statement word, holds it until it advances.
// ----------------------------------------------------------------------------
module rlt_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rlt_in_if.sink            i_in,
    input  logic              i_advance,
    output logic              o_valid,
    output rlt_pkg::t_item    o_item
);

    logic           r_valid;
    rlt_pkg::t_item r_item;
    logic           accept;

    // Take a word when empty or when the held word moves on this cycle
    assign i_in.ready = !r_valid || i_advance;
    assign accept     = i_in.valid && i_in.ready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.operation   <= i_in.operation;
            r_item.address_ref <= i_in.address_ref;
            r_item.access_size <= i_in.access_size;
            r_item.result_ref  <= i_in.result_ref;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/rlt_table.sv =====
// ----------------------------------------------------------------------------
// rlt_table
// Fully associative load table: parallel tag compare, lowest-free insert,
// flush that clears all valid bits at once.
// ----------------------------------------------------------------------------
module rlt_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rlt_pkg::t_req                       i_req,
    output rlt_pkg::t_result                    o_result,
    output logic [rlt_pkg::TABLE_ENTRIES-1:0]   o_valid_mask
);

    localparam int N = rlt_pkg::TABLE_ENTRIES;
    localparam int K = rlt_pkg::KEY_W;

    logic [N-1:0]               r_valid;
    logic [K-1:0]               r_addr  [N];
    logic [rlt_pkg::SIZE_W-1:0] r_size  [N];
    logic [K-1:0]               r_value [N];

    logic [N-1:0]  hit_vec;
    logic [N-1:0]  hit_oh;
    logic [N-1:0]  free_oh;
    logic [K-1:0]  hit_value;
    logic [K-1:0]  key_addr;
    logic [K-1:0]  key_res;
    logic          is_load;
    logic          any_hit;
    logic          any_free;
    logic          do_insert;
    logic          do_flush;

    assign key_addr = i_req.item.address_ref[K-1:0];
    assign key_res  = i_req.item.result_ref[K-1:0];
    assign is_load  = (i_req.item.operation == rlt_pkg::OP_LOAD);

    // Compare the key against every valid entry
    always_comb begin
        for (int i = 0; i < N; i++) begin
            hit_vec[i] = r_valid[i] && (r_addr[i] == key_addr)
                         && (r_size[i] == i_req.item.access_size);
        end
    end

    // Pick lowest hit and lowest free entry
    assign hit_oh  = hit_vec & (~hit_vec + N'(1));
    assign free_oh = ~r_valid & (r_valid + N'(1));
    assign any_hit  = |hit_vec;
    assign any_free = ~&r_valid;

    // Select the stored value of the hit entry
    always_comb begin
        hit_value = '0;
        for (int i = 0; i < N; i++) begin
            hit_value = hit_value | (hit_oh[i] ? r_value[i] : K'(0));
        end
    end

    // Form the result word
    always_comb begin
        o_result.rewrite_as_copy = is_load && any_hit;
        o_result.copy_source_ref = (is_load && any_hit) ? rlt_pkg::REF_W'(hit_value)
                                                        : '0;
        o_result.insert_dropped  = is_load && !any_hit && !any_free;
    end

    assign do_insert = i_req.commit && is_load && !any_hit && any_free;
    assign do_flush  = i_req.commit && (i_req.item.operation == rlt_pkg::OP_FLUSH);

    // Update valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (do_flush) begin
            r_valid <= '0;
        end else if (do_insert) begin
            r_valid <= r_valid | free_oh;
        end
    end

    // Write entry contents on insert
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N; i++) begin
            if (do_insert && free_oh[i]) begin
                r_addr[i]  <= key_addr;
                r_size[i]  <= i_req.item.access_size;
                r_value[i] <= key_res;
            end
        end
    end

    assign o_valid_mask = r_valid;

endmodule

// ===== rtl/redundant_load_table.sv =====
// ----------------------------------------------------------------------------
// redundant_load_table
// Marks plain loads that repeat an earlier (address, size) pair as copies
// of the earlier result; flush statements empty the table.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  i_in    | in  | operation, address_ref, access_size, result_ref
//  o_out   | out | rewrite_as_copy, copy_source_ref, insert_dropped
//
//  One statement per cycle while o_out is not stalled; a result passes the
//  input register, then the combinational parallel tag compare, into the result register.
//  Reset clears all entry valid bits at once; no clearing pass.
//  A stalled output holds the result register; the input register then
//  holds one more word before i_in.ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module redundant_load_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rlt_in_if.sink    i_in,
    rlt_out_if.source o_out
);

    logic                                s1_valid;
    rlt_pkg::t_item                      s1_item;
    logic                                advance;
    rlt_pkg::t_req                       req;
    rlt_pkg::t_result                    lookup;
    logic [rlt_pkg::TABLE_ENTRIES-1:0]   valid_mask;

    logic                                r_out_valid;
    rlt_pkg::t_result                    r_out;

    // Move the held statement on when the result register is free
    assign advance = s1_valid && (!r_out_valid || o_out.ready);

    rlt_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_valid   (s1_valid),
        .o_item    (s1_item)
    );

    assign req.commit = advance;
    assign req.item   = s1_item;

    rlt_table u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .o_result     (lookup),
        .o_valid_mask (valid_mask)
    );

    // Result register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture result word
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= lookup;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.rewrite_as_copy = r_out.rewrite_as_copy;
    assign o_out.copy_source_ref = r_out.copy_source_ref;
    assign o_out.insert_dropped  = r_out.insert_dropped;

    // A copy source only accompanies a rewrite
    `ASSERT_SAME(a_source_zero, r_out_valid && !r_out.rewrite_as_copy,
                 r_out.copy_source_ref == '0)
    // A flush empties the table
    `ASSERT_NEXT(a_flush_clears, advance && s1_item.operation == rlt_pkg::OP_FLUSH,
                 valid_mask == '0)
    // A dropped insert only happens with every entry in use
    `ASSERT_SAME(a_drop_full, advance && lookup.insert_dropped, &valid_mask)
    // A recorded miss claims exactly one entry
    `ASSERT_NEXT(a_insert_one,
                 advance && s1_item.operation == rlt_pkg::OP_LOAD
                 && !lookup.rewrite_as_copy && !lookup.insert_dropped,
                 $countones(valid_mask) == $countones($past(valid_mask)) + 1)

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the redundant load table. Statement words go in
// through bursts with random gaps, and the result port stalls in patterns
// of its own. A scoreboard keeps its own copy of the load table. It
// predicts the copy mark, the copy source and the dropped-insert flag of
// every accepted word, and checks each result word in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlt_pkg::*;

    // Spare operation code, handled as another statement
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1650;
    localparam int MAX_REPORTS  = 40;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow load table and queue of predicted result words
    // ------------------------------------------------------------------------
    class load_table_scoreboard;
        bit                slot_used  [TABLE_ENTRIES];
        logic [KEY_W-1:0]  slot_addr  [TABLE_ENTRIES];
        logic [SIZE_W-1:0] slot_size  [TABLE_ENTRIES];
        logic [KEY_W-1:0]  slot_value [TABLE_ENTRIES];
        t_result           predicted_rewrites[$];
        int                mismatches;

        function new();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return predicted_rewrites.size();
        endfunction

        // Update the shadow table and queue the result this word must give
        function void record_statement(t_item it);
            t_result          r;
            int               hit;
            int               free_slot;
            logic [KEY_W-1:0] key;
            r         = '0;
            hit       = -1;
            free_slot = -1;
            key       = it.address_ref[KEY_W-1:0];
            case (it.operation)
                OP_LOAD: begin
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (slot_used[i]) begin
                            if (hit < 0 && slot_addr[i] == key && slot_size[i] == it.access_size)
                                hit = i;
                        end else if (free_slot < 0) begin
                            free_slot = i;
                        end
                    end
                    if (hit >= 0) begin
                        r.rewrite_as_copy = 1'b1;
                        r.copy_source_ref = slot_value[hit];
                    end else if (free_slot >= 0) begin
                        slot_used[free_slot]  = 1'b1;
                        slot_addr[free_slot]  = key;
                        slot_size[free_slot]  = it.access_size;
                        slot_value[free_slot] = it.result_ref[KEY_W-1:0];
                    end else begin
                        r.insert_dropped = 1'b1;
                    end
                end
                OP_FLUSH: begin
                    foreach (slot_used[i]) slot_used[i] = 1'b0;
                end
                default: ;
            endcase
            predicted_rewrites = {predicted_rewrites, r};
        endfunction

        function void flag(string field, logic [REF_W-1:0] want, logic [REF_W-1:0] got);
            if (mismatches < MAX_REPORTS)
                $display("%0t mismatch on %s: expected %h actual %h", $time, field, want, got);
            mismatches++;
        endfunction

        // Compare a result word with the oldest prediction, field by field
        function void check_result(t_result got);
            t_result want;
            if (predicted_rewrites.size() == 0) begin
                flag("unexpected result word", '0, got.copy_source_ref);
                return;
            end
            want = predicted_rewrites.pop_front();
            if (got.rewrite_as_copy !== want.rewrite_as_copy)
                flag("rewrite_as_copy", REF_W'(want.rewrite_as_copy),
                     REF_W'(got.rewrite_as_copy));
            if (got.copy_source_ref !== want.copy_source_ref)
                flag("copy_source_ref", want.copy_source_ref, got.copy_source_ref);
            if (got.insert_dropped !== want.insert_dropped)
                flag("insert_dropped", REF_W'(want.insert_dropped),
                     REF_W'(got.insert_dropped));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rlt_in_if  in_ch();
    rlt_out_if out_ch();

    redundant_load_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    load_table_scoreboard table_sb = new();

    int burst_left = 0;
    int cycle_count = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Note every accepted statement word
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            table_sb.record_statement(make_item(in_ch.operation, in_ch.address_ref,
                                                in_ch.access_size, in_ch.result_ref));
    end

    // Check every accepted result word
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.rewrite_as_copy = out_ch.rewrite_as_copy;
            got.copy_source_ref = out_ch.copy_source_ref;
            got.insert_dropped  = out_ch.insert_dropped;
            table_sb.check_result(got);
        end
    end

    // Result port backpressure: a random mode, redrawn when its random hold count runs out
    initial begin
        int mode;
        int hold;
        int run;
        bit stalled;
        int tick;
        mode    = 0;
        hold    = 0;
        run     = 0;
        stalled = 1'b0;
        tick    = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold == 0) begin
                mode = $urandom_range(0, 3);
                hold = $urandom_range(50, 300);
            end
            hold--;
            tick++;
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: begin
                    if (run == 0) begin
                        stalled = !stalled;
                        run     = stalled ? $urandom_range(1, 12) : $urandom_range(1, 8);
                    end
                    run--;
                    out_ch.ready <= !stalled;
                end
                default: out_ch.ready <= tick[1];
            endcase
        end
    end

    // Cycle limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic t_item make_item(logic [OP_W-1:0] op, logic [REF_W-1:0] addr,
                                        logic [SIZE_W-1:0] size, logic [REF_W-1:0] res);
        t_item it;
        it.operation   = op;
        it.address_ref = addr;
        it.access_size = size;
        it.result_ref  = res;
        return it;
    endfunction

    // Present one word and hold it until accepted
    task automatic send_statement(t_item it);
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= it.operation;
        in_ch.address_ref <= it.address_ref;
        in_ch.access_size <= it.access_size;
        in_ch.result_ref  <= it.result_ref;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Send in bursts of random length with random gaps between them
    task automatic issue(t_item it, bit no_gaps = 1'b0);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        send_statement(it);
    endtask

    // Hold off the sender until every predicted result word has arrived
    task automatic wait_results_settled();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (table_sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Hits, a size mismatch, a flush, the extremes, then fill and overflow
    task automatic run_directed();
        issue(make_item(OP_LOAD,  16'h1234, 2'd0, 16'h0001));
        issue(make_item(OP_LOAD,  16'h1234, 2'd0, 16'h0002));
        issue(make_item(OP_LOAD,  16'h1234, 2'd1, 16'h0003));
        issue(make_item(OP_OTHER, 16'h1234, 2'd0, 16'h0005));
        issue(make_item(OP_SPARE, 16'h1234, 2'd0, 16'h0006));
        issue(make_item(OP_LOAD,  16'h1234, 2'd0, 16'h0007));
        issue(make_item(OP_FLUSH, 16'h1234, 2'd0, 16'h0008));
        issue(make_item(OP_LOAD,  16'h1234, 2'd0, 16'hAAAA));
        issue(make_item(OP_LOAD,  16'hFFFF, 2'd3, 16'hFFFF));
        issue(make_item(OP_LOAD,  16'hFFFF, 2'd3, 16'h0000));
        issue(make_item(OP_LOAD,  16'h0000, 2'd0, 16'h0000));
        for (int k = 0; k < TABLE_ENTRIES - 3; k++)
            issue(make_item(OP_LOAD, REF_W'(16'h0100 + k), k[1:0], REF_W'(16'h8000 + k)));
        // table is full now
        issue(make_item(OP_LOAD,  16'h5555, 2'd2, 16'h4321));
        issue(make_item(OP_LOAD,  16'h0000, 2'd0, 16'h1111));
    endtask

    // Loads drawn from a small pool of keys, so hits, fills and drops occur
    task automatic run_pool_sequence(int pool_n, int len, bit no_gaps);
        logic [REF_W-1:0]  pool_addr [40];
        logic [SIZE_W-1:0] pool_size [40];
        int                pick;
        int                roll;
        for (int i = 0; i < pool_n; i++) begin
            pool_addr[i] = REF_W'($urandom);
            pool_size[i] = SIZE_W'($urandom_range(0, 3));
        end
        if ($urandom_range(0, 1))
            issue(make_item(OP_FLUSH, REF_W'($urandom), SIZE_W'($urandom),
                            REF_W'($urandom)), no_gaps);
        for (int n = 0; n < len; n++) begin
            pick = $urandom_range(0, pool_n - 1);
            roll = $urandom_range(0, 99);
            if (roll < 70)
                issue(make_item(OP_LOAD, pool_addr[pick], pool_size[pick],
                                REF_W'($urandom)), no_gaps);
            else if (roll < 75)
                issue(make_item(OP_FLUSH, REF_W'($urandom), SIZE_W'($urandom),
                                REF_W'($urandom)), no_gaps);
            else if (roll < 88)
                issue(make_item(OP_OTHER, pool_addr[pick], pool_size[pick],
                                REF_W'($urandom)), no_gaps);
            else if (roll < 92)
                issue(make_item(OP_SPARE, pool_addr[pick], pool_size[pick],
                                REF_W'($urandom)), no_gaps);
            else
                issue(make_item(OP_LOAD, REF_W'($urandom), SIZE_W'($urandom),
                                REF_W'($urandom)), no_gaps);
        end
    endtask

    // Stimulus
    initial begin
        int words_left;
        int len;
        int pool_n;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.operation   <= OP_OTHER;
        in_ch.address_ref <= '0;
        in_ch.access_size <= '0;
        in_ch.result_ref  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        wait_results_settled();

        words_left = RANDOM_WORDS;
        while (words_left > 0) begin
            len = $urandom_range(20, 80);
            if ($urandom_range(0, 4) == 0) begin
                // raw noise: any code, any field value
                len = $urandom_range(10, 30);
                for (int n = 0; n < len; n++)
                    issue(make_item(OP_W'($urandom), REF_W'($urandom), SIZE_W'($urandom),
                                    REF_W'($urandom)));
            end else begin
                case ($urandom_range(0, 3))
                    0:       pool_n = 4;
                    1:       pool_n = 12;
                    2:       pool_n = 20;
                    default: pool_n = 40;
                endcase
                run_pool_sequence(pool_n, len, $urandom_range(0, 5) == 0);
            end
            words_left -= len;
            if ($urandom_range(0, 3) == 0)
                wait_results_settled();
        end

        wait_results_settled();
        repeat (8) @(posedge i_clk);
        if (table_sb.mismatches == 0 && table_sb.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
